[rtl/polyphonic_sine_synth_top_defines.svh]
// Assertion macros for the synthesizer RTL (used by pss_ctrl).
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef POLYPHONIC_SINE_SYNTH_TOP_DEFINES_SVH
`define POLYPHONIC_SINE_SYNTH_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pss_pkg.sv]
`default_nettype none
package pss_pkg;

  // Fixed field widths
  localparam int FREQ_W   = 23;
  localparam int VIDX_W   = 3;
  localparam int RATE_W   = 18;
  localparam int SAMPLE_W = 16;
  localparam int AMP_W    = 12;

  localparam logic [AMP_W-1:0]  AMPLITUDE   = 12'd4095;
  localparam logic [RATE_W-1:0] RESET_RATE  = 18'd44100;
  localparam logic [63:0]       HALF_PI_Q62 = 64'h6487ED5110B4611A;

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_op;
    logic div_step;
    logic div_store;
    logic tick_read;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;
    logic voice_last;
  } stat_t;

endpackage
`default_nettype wire

[rtl/pss_ctrl.sv]
`default_nettype none
`include "polyphonic_sine_synth_top_defines.svh"
module pss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_opcode,
  output logic          out_valid,
  input  logic          out_ready,
  output pss_pkg::cmd_t cmd,
  input  pss_pkg::stat_t stat
);
  import pss_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DIV    = 6'b000010,
    ST_STORE  = 6'b000100,
    ST_TICK   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Sequence one item through divide or voice sweep
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.load_op   = in_acc;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (opcode_t'(in_opcode) == OP_TICK) ? ST_TICK : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.div_store = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_TICK: begin
        cmd.tick_read = 1'b1;
        if (stat.voice_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Drop valid when taken, raise it on a new result
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PSS_ASSERT_SAME(a_no_overwrite, cmd.out_load,
                   (state_r == ST_FINISH) && (!out_valid_r || out_ready),
                   "result register loaded while a result is still pending")
  `PSS_ASSERT_NEXT(a_accept_starts, in_valid && in_ready,
                   (state_r == ST_DIV) || (state_r == ST_TICK),
                   "accepted item did not start work")
  `PSS_ASSERT_SAME(a_store_after_div, state_r == ST_STORE,
                   $past(stat.div_last) && $past(state_r == ST_DIV),
                   "increment stored before the divide finished")

endmodule
`default_nettype wire

[rtl/pss_datapath.sv]
`default_nettype none
module pss_datapath #(
  parameter int VOICES          = 8,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pss_pkg::cmd_t                  cmd,
  output pss_pkg::stat_t                 stat,
  input  logic                           cfg_wr_en,
  input  logic [pss_pkg::RATE_W-1:0]     cfg_wr_data,
  input  logic [pss_pkg::VIDX_W-1:0]     in_voice_index,
  input  logic [pss_pkg::FREQ_W-1:0]     in_frequency_q8,
  output logic signed [pss_pkg::SAMPLE_W-1:0] out_sample
);
  import pss_pkg::*;

  localparam int VW      = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int QBITS   = TABLE_ADDR_BITS - 2;
  localparam int QUARTER = 1 << QBITS;
  localparam int QIDX_W  = TABLE_ADDR_BITS - 1;
  localparam int DIVD_W  = FREQ_W + PHASE_BITS - 8;
  localparam int DCNT_W  = $clog2(DIVD_W);

  typedef logic [AMP_W-1:0] qtab_t [QUARTER+1];

  // Q62 product, truncated
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // 4095*sin(pi/2 * m / QUARTER), truncated, by Taylor series in Q62
  function automatic logic [AMP_W-1:0] quarter_sine(input int unsigned m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] mag;
    if (m == 0) begin
      return '0;
    end
    if (m >= QUARTER) begin
      return AMPLITUDE;
    end
    x    = (HALF_PI_Q62 >> QBITS) * 64'(m);
    x2   = mul_q62(x, x);
    s    = x;
    term = mul_q62(x, x2) / 64'd6;      s = s - term;
    term = mul_q62(term, x2) / 64'd20;  s = s + term;
    term = mul_q62(term, x2) / 64'd42;  s = s - term;
    term = mul_q62(term, x2) / 64'd72;  s = s + term;
    term = mul_q62(term, x2) / 64'd110; s = s - term;
    term = mul_q62(term, x2) / 64'd156; s = s + term;
    term = mul_q62(term, x2) / 64'd210; s = s - term;
    term = mul_q62(term, x2) / 64'd272; s = s + term;
    term = mul_q62(term, x2) / 64'd342; s = s - term;
    term = mul_q62(term, x2) / 64'd420; s = s + term;
    term = mul_q62(term, x2) / 64'd506; s = s - term;
    term = mul_q62(term, x2) / 64'd600; s = s + term;
    mag  = ((s >> 20) * 64'(AMPLITUDE)) >> 42;
    return mag[AMP_W-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int m = 0; m <= QUARTER; m++) begin
      t[m] = quarter_sine(m);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // Configuration register
  logic [RATE_W-1:0] rate_hz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_hz_r <= RESET_RATE;
    end else if (cfg_wr_en) begin
      rate_hz_r <= cfg_wr_data;
    end
  end

  // Divider: restoring, one quotient bit a cycle
  logic [VIDX_W-1:0]     vidx_r;
  logic [DIVD_W-1:0]     dvd_r;
  logic [RATE_W-1:0]     rem_r;
  logic [PHASE_BITS-1:0] quot_r;
  logic [DCNT_W-1:0]     dcnt_r;
  logic [RATE_W:0]       trial;
  logic [RATE_W:0]       diff;
  logic                  qbit;

  assign trial = {rem_r, dvd_r[DIVD_W-1]};
  assign diff  = trial - {1'b0, rate_hz_r};
  assign qbit  = (trial >= {1'b0, rate_hz_r});

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      vidx_r <= in_voice_index;
      dvd_r  <= {in_frequency_q8, {(PHASE_BITS-8){1'b0}}};
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      dvd_r  <= {dvd_r[DIVD_W-2:0], 1'b0};
      rem_r  <= qbit ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      quot_r <= {quot_r[PHASE_BITS-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.load_op) begin
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  // Voice state and sweep counter
  logic [PHASE_BITS-1:0]      phase_r [VOICES];
  logic [PHASE_BITS-1:0]      inc_r   [VOICES];
  logic [VW-1:0]              vcnt_r;
  logic [PHASE_BITS-1:0]      cur_phase;
  logic [TABLE_ADDR_BITS-1:0] taddr;
  logic [QBITS-1:0]           roff;
  logic [QIDX_W-1:0]          qidx;

  assign cur_phase = phase_r[vcnt_r];
  assign taddr     = cur_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign roff      = taddr[QBITS-1:0];
  // Mirror the odd quadrants
  assign qidx      = taddr[QBITS] ? (QIDX_W'(QUARTER) - {1'b0, roff}) : {1'b0, roff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < VOICES; v++) begin
        phase_r[v] <= '0;
        inc_r[v]   <= '0;
      end
    end else begin
      if (cmd.div_store && ({1'b0, vidx_r} < (VIDX_W+1)'(VOICES))) begin
        inc_r[vidx_r[VW-1:0]] <= (rate_hz_r == '0) ? '0 : quot_r;
      end
      if (cmd.tick_read) begin
        phase_r[vcnt_r] <= cur_phase + inc_r[vcnt_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= '0;
    end else if (cmd.load_op) begin
      vcnt_r <= '0;
    end else if (cmd.tick_read) begin
      vcnt_r <= vcnt_r + 1'b1;
    end
  end

  assign stat.div_last   = (dcnt_r == DCNT_W'(DIVD_W-1));
  assign stat.voice_last = (vcnt_r == VW'(VOICES-1));

  // Quarter-wave table read, registered
  logic [AMP_W-1:0] rom_mag_r;
  logic             neg_r;
  logic             rom_vld_r;

  always_ff @(posedge clk) begin
    rom_mag_r <= QTAB[qidx];
    neg_r     <= taddr[TABLE_ADDR_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_vld_r <= 1'b0;
    end else begin
      rom_vld_r <= cmd.tick_read;
    end
  end

  // Accumulate signed table values, wrapping at 16 bits
  logic signed [AMP_W:0]      mag_s;
  logic signed [AMP_W:0]      val_s;
  logic signed [SAMPLE_W-1:0] sum_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  assign mag_s = {1'b0, rom_mag_r};
  assign val_s = neg_r ? -mag_s : mag_s;

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      sum_r <= '0;
    end else if (rom_vld_r) begin
      sum_r <= sum_r + {{(SAMPLE_W-AMP_W-1){val_s[AMP_W]}}, val_s};
    end
  end

  // Hold the result for the output channel
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_r <= sum_r;
    end
  end

  assign out_sample = out_sample_r;

endmodule
`default_nettype wire

[rtl/polyphonic_sine_synth_top.sv]
// Set item: busy while the bit-serial divider turns the frequency into a phase
//   increment and while that increment is stored.
// Tick item: the voices share one table read port, one per cycle; after ST_DRAIN the
//   result loads in ST_FINISH once the output register is free, then a new item is taken.
// One item is in work at a time; a finished result waits in an output register.
// Reset (rst_n low, synchronous): phases and increments cleared, rate 44100 Hz.
`default_nettype none
module polyphonic_sine_synth_top #(
  parameter int VOICES          = 8,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic [pss_pkg::VIDX_W-1:0]         in_voice_index,
  input  logic [pss_pkg::FREQ_W-1:0]         in_frequency_q8,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pss_pkg::SAMPLE_W-1:0] out_sample,
  input  logic                               cfg_wr_en,
  input  logic [pss_pkg::RATE_W-1:0]         cfg_wr_data
);
  import pss_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pss_datapath #(
    .VOICES          (VOICES),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .PHASE_BITS      (PHASE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_voice_index  (in_voice_index),
    .in_frequency_q8 (in_frequency_q8),
    .out_sample      (out_sample)
  );

endmodule
`default_nettype wire
